// ===== rtl/core/fsp_pkg.sv =====
// Shared types and constants for the format spec parser.
package fsp_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned ValueW = 32;
    localparam int unsigned ModW   = 4;
    localparam int unsigned FlagN  = 5;

    localparam logic [ValueW-1:0] SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [ValueW-1:0] MINUS_ONE = 32'hFFFF_FFFF;
    localparam logic [ValueW-1:0] NEG_MIN   = 32'h8000_0000;
    // largest accumulator that can take one more digit without overflow
    localparam logic [ValueW-1:0] DIGIT_LIMIT = 32'd214748364;

    // characters
    localparam logic [CharW-1:0] CH_NUL   = 8'h00;
    localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
    localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharW-1:0] CH_NINE  = 8'h39;
    localparam logic [CharW-1:0] CH_HASH  = 8'h23;
    localparam logic [CharW-1:0] CH_SPACE = 8'h20;
    localparam logic [CharW-1:0] CH_STAR  = 8'h2A;
    localparam logic [CharW-1:0] CH_DOT   = 8'h2E;
    localparam logic [CharW-1:0] CH_H     = 8'h68;
    localparam logic [CharW-1:0] CH_L     = 8'h6C;
    localparam logic [CharW-1:0] CH_J     = 8'h6A;
    localparam logic [CharW-1:0] CH_Z     = 8'h7A;

    // flag bit positions
    localparam int unsigned FL_PLUS  = 0;
    localparam int unsigned FL_MINUS = 1;
    localparam int unsigned FL_ZERO  = 2;
    localparam int unsigned FL_HASH  = 3;
    localparam int unsigned FL_SPACE = 4;

    // length modifier codes; the doubled form is the single code plus one
    localparam logic [ModW-1:0] MOD_NONE = 4'd0;
    localparam logic [ModW-1:0] MOD_H    = 4'd1;
    localparam logic [ModW-1:0] MOD_L    = 4'd3;
    localparam logic [ModW-1:0] MOD_J    = 4'd5;
    localparam logic [ModW-1:0] MOD_Z    = 4'd7;

    typedef struct packed {
        logic [ValueW-1:0] arg_value;
        logic              starts_spec;
        logic [CharW-1:0]  spec_char;
    } fsp_item_t;

    typedef struct packed {
        logic              malformed;
        logic [CharW-1:0]  conversion_char;
        logic [ModW-1:0]   length_modifier;
        logic [ValueW-1:0] precision_value;
        logic [ValueW-1:0] field_width;
        logic              flag_space;
        logic              flag_hash;
        logic              flag_zero;
        logic              flag_minus;
        logic              flag_plus;
    } fsp_result_t;

endpackage

// ===== rtl/core/fsp_sat_digit.sv =====
// Saturating decimal accumulate: acc * 10 + digit, clamped at the positive maximum.
module fsp_sat_digit
(
    input  logic [fsp_pkg::ValueW-1:0] acc,
    input  logic [3:0]                 digit,
    output logic [fsp_pkg::ValueW-1:0] sum
);
    import fsp_pkg::*;

    logic over;

    assign over = (acc > DIGIT_LIMIT) || ((acc == DIGIT_LIMIT) && (digit > 4'd7));

    // times ten as two shifts and an add
    assign sum = over ? SAT_MAX
                      : ((acc << 3) + (acc << 1) + {{(ValueW-4){1'b0}}, digit});
endmodule

// ===== rtl/core/fsp_parser.sv =====
// Spec parsing state machine with its result register.
module fsp_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  fsp_pkg::fsp_item_t  item,
    output logic                item_take,
    output logic                res_valid,
    output fsp_pkg::fsp_result_t res,
    input  logic                res_ready
);
    import fsp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_WDIG,
        PH_WSKIP,
        PH_PSTART,
        PH_PDIG,
        PH_PSKIP,
        PH_MOD
    } phase_t;

    phase_t            phase_reg,     phase_next;
    logic [FlagN-1:0]  flag_set_reg,  flag_set_next;
    logic [ValueW-1:0] width_reg,     width_next;
    logic [ValueW-1:0] prec_reg,      prec_next;
    logic [ModW-1:0]   mod_reg,       mod_next;
    logic              res_valid_reg;
    fsp_result_t       res_reg,       res_next;
    logic              emit_next;

    logic [CharW-1:0]  c;
    logic [ValueW-1:0] arg;
    logic              neg;
    logic              is_dig;
    logic [FlagN-1:0]  fbit;
    logic [ModW-1:0]   kcode;
    logic [ValueW-1:0] dig_acc;
    logic [ValueW-1:0] dig_sum;

    assign c      = item.spec_char;
    assign arg    = item.arg_value;
    assign neg    = arg[ValueW-1];
    assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

    always_comb
    begin
        case (c)
            CH_PLUS:  fbit = FlagN'(1) << FL_PLUS;
            CH_MINUS: fbit = FlagN'(1) << FL_MINUS;
            CH_ZERO:  fbit = FlagN'(1) << FL_ZERO;
            CH_HASH:  fbit = FlagN'(1) << FL_HASH;
            CH_SPACE: fbit = FlagN'(1) << FL_SPACE;
            default:  fbit = '0;
        endcase
    end

    always_comb
    begin
        case (c)
            CH_H:    kcode = MOD_H;
            CH_L:    kcode = MOD_L;
            CH_J:    kcode = MOD_J;
            CH_Z:    kcode = MOD_Z;
            default: kcode = MOD_NONE;
        endcase
    end

    // only one of the digit phases can be active for a given character
    assign dig_acc = (phase_reg == PH_PDIG) ? prec_reg : width_reg;

    fsp_sat_digit u_digit
    (
        .acc   (dig_acc),
        .digit (c[3:0]),
        .sum   (dig_sum)
    );

    // phases only move forward within one character, so the fall-through
    // chain is a fixed sequence of guarded blocks
    always_comb
    begin
        logic done;
        logic [CharW-1:0] conv;
        logic bad;

        phase_next    = phase_reg;
        flag_set_next = flag_set_reg;
        width_next    = width_reg;
        prec_next     = prec_reg;
        mod_next      = mod_reg;
        emit_next     = 1'b0;
        conv          = CH_NUL;
        bad           = 1'b0;
        done          = 1'b0;

        if (item.starts_spec)
        begin
            flag_set_next = '0;
            width_next    = MINUS_ONE;
            prec_next     = MINUS_ONE;
            mod_next      = MOD_NONE;
            phase_next    = PH_FLAGS;
            if (c == CH_NUL)
            begin
                emit_next  = 1'b1;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
        end

        if (!done && phase_next == PH_IDLE)
            done = 1'b1;

        if (!done && phase_next == PH_FLAGS)
        begin
            if (fbit != '0)
            begin
                flag_set_next = flag_set_next | fbit;
                done = 1'b1;
            end
            else if (c == CH_STAR)
            begin
                if (neg)
                begin
                    flag_set_next[FL_MINUS] = 1'b1;
                    width_next = (arg == NEG_MIN) ? SAT_MAX : (~arg + 1'b1);
                end
                else
                    width_next = arg;
                phase_next = PH_WSKIP;
                done = 1'b1;
            end
            else if (is_dig)
            begin
                width_next = {{(ValueW-4){1'b0}}, c[3:0]};
                phase_next = PH_WDIG;
                done = 1'b1;
            end
            else
            begin
                width_next = '0;
                phase_next = PH_WSKIP;
            end
        end

        if (!done && phase_next == PH_WDIG)
        begin
            if (is_dig)
            begin
                width_next = dig_sum;
                done = 1'b1;
            end
            else
                phase_next = PH_WSKIP;
        end

        if (!done && phase_next == PH_WSKIP)
        begin
            if (is_dig)
                done = 1'b1;
            else if (c == CH_DOT)
            begin
                phase_next = PH_PSTART;
                done = 1'b1;
            end
            else
                phase_next = PH_MOD;
        end

        if (!done && phase_next == PH_PSTART)
        begin
            if (c == CH_STAR)
            begin
                prec_next  = neg ? MINUS_ONE : arg;
                phase_next = PH_PSKIP;
                done = 1'b1;
            end
            else if (is_dig)
            begin
                prec_next  = {{(ValueW-4){1'b0}}, c[3:0]};
                phase_next = PH_PDIG;
                done = 1'b1;
            end
            else
            begin
                prec_next  = '0;
                phase_next = PH_MOD;
            end
        end

        if (!done && phase_next == PH_PDIG)
        begin
            if (is_dig)
            begin
                prec_next = dig_sum;
                done = 1'b1;
            end
            else
                phase_next = PH_MOD;
        end

        if (!done && phase_next == PH_PSKIP)
        begin
            if (is_dig)
                done = 1'b1;
            else
                phase_next = PH_MOD;
        end

        if (!done && phase_next == PH_MOD)
        begin
            if (kcode == MOD_NONE)
            begin
                emit_next  = 1'b1;
                conv       = c;
                phase_next = PH_IDLE;
            end
            else if (mod_next == MOD_NONE)
                mod_next = kcode;
            else if (mod_next == kcode)
                mod_next = kcode + 1'b1;
            else
            begin
                // third letter or mismatched pair
                emit_next  = 1'b1;
                bad        = 1'b1;
                phase_next = PH_IDLE;
            end
        end

        res_next.flag_plus       = flag_set_next[FL_PLUS];
        res_next.flag_minus      = flag_set_next[FL_MINUS];
        res_next.flag_zero       = flag_set_next[FL_ZERO];
        res_next.flag_hash       = flag_set_next[FL_HASH];
        res_next.flag_space      = flag_set_next[FL_SPACE];
        res_next.field_width     = width_next;
        res_next.precision_value = prec_next;
        res_next.length_modifier = mod_next;
        res_next.conversion_char = conv;
        res_next.malformed       = bad;
    end

    assign item_take = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            flag_set_reg  <= '0;
            width_reg     <= MINUS_ONE;
            prec_reg      <= MINUS_ONE;
            mod_reg       <= MOD_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                phase_reg    <= phase_next;
                flag_set_reg <= flag_set_next;
                width_reg    <= width_next;
                prec_reg     <= prec_next;
                mod_reg      <= mod_next;
            end
            if (item_take && emit_next)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    a_emit_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && emit_next |=> phase_reg == PH_IDLE)
        else $error("phase not idle after a result");

    a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && !item.starts_spec && phase_reg == PH_IDLE |-> !emit_next)
        else $error("result from a character outside a spec");

    a_malformed_conv: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.malformed |-> res_reg.conversion_char == CH_NUL)
        else $error("malformed result carries a conversion character");

    a_width_floor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.field_width[ValueW-1] |-> res_reg.field_width == MINUS_ONE)
        else $error("field width below minus one");

endmodule

// ===== rtl/core/format_spec_parser.sv =====
// Top level of the printf conversion spec parser, one character per request.
// Path: a taken character waits in the input register, is parsed into the result
// register when the parser takes it, and any result it closes is offered from there.
// Throughput: one character per cycle, set by the single parse stage between
// the input register and the result register; a result left waiting stalls intake.
// Reset: rst_n (async, active low) empties both registers and returns to idle.
module format_spec_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] spec_char, [39:8] arg_value
    input  logic [0:0]  s_tuser,   // [0] starts_spec
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [0] flag_plus, [1] flag_minus, [2] flag_zero,
                                   // [3] flag_hash, [4] flag_space, [36:5] field_width,
                                   // [68:37] precision_value, [72:69] length_modifier,
                                   // [80:73] conversion_char, [87:81] zero
    output logic [0:0]  m_tuser    // [0] malformed
);
    import fsp_pkg::*;

    logic        in_valid_reg;
    fsp_item_t   in_item_reg;
    logic        item_take;
    fsp_result_t res;

    // input register refills in the same cycle the parser drains it
    assign s_tready = !in_valid_reg || item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.spec_char   <= s_tdata[7:0];
            in_item_reg.arg_value   <= s_tdata[39:8];
            in_item_reg.starts_spec <= s_tuser[0];
        end
    end

    fsp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .item_take  (item_take),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = {7'b0,
                      res.conversion_char,
                      res.length_modifier,
                      res.precision_value,
                      res.field_width,
                      res.flag_space,
                      res.flag_hash,
                      res.flag_zero,
                      res.flag_minus,
                      res.flag_plus};
    assign m_tuser = res.malformed;

endmodule

// ===== tb/sv/tb_format_spec_parser.sv =====
// Self-checking testbench for format_spec_parser: directed and random specs against a predictor.
`timescale 1ns / 1ps

module tb_format_spec_parser;
    import fsp_pkg::*;

    // Longest run of cycles with no request moving on either side before we give up.
    // A correct run never gets near this limit.
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_CHARS = 1200;
    localparam int DRAIN_EVERY = 300;

    // parser phases, same order as the block walks through a spec
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_WDIG,
        PH_WSKIP,
        PH_PSTART,
        PH_PDIG,
        PH_PSKIP,
        PH_MOD
    } phase_t;

    // one character request waiting to go out; drain holds it back until every
    // pending result has come out of the block
    typedef struct {
        fsp_item_t req;
        bit        drain;
    } pend_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // [7:0] spec_char, [39:8] arg_value
    logic [0:0]  s_tuser = '0;   // [0] starts_spec
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;        // flags [4:0], width [36:5], precision [68:37],
                                 // modifier [72:69], conversion [80:73], zero pad [87:81]
    logic [0:0]  m_tuser;        // [0] malformed

    format_spec_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a shadow copy of what the parser has gathered so far
    // ------------------------------------------------------------------
    phase_t      phase_q = PH_IDLE;
    logic [4:0]  flags_q = '0;
    logic [31:0] width_q = MINUS_ONE;
    logic [31:0] prec_q  = MINUS_ONE;
    logic [3:0]  mod_q   = MOD_NONE;

    pend_char_t  chars_to_send[$];
    fsp_result_t parsed_specs_due[$];

    // stimulus builder state
    bit spec_open;
    bit drain_next;
    int next_drain;
    int char_total;

    // handshake bookkeeping
    bit          char_taken;
    bit          res_taken;
    int          chars_sent;
    int          stall_cycles;
    int          fails;
    int          char_wait;
    int          char_run_left;
    bit          char_no_idle;
    int          res_wait;
    int          res_run_left;
    bit          res_no_idle;
    pend_char_t  char_next;
    fsp_result_t spec_shape;

    function automatic logic [4:0] flag_of(input logic [7:0] c);
        case (c)
            CH_PLUS:  return 5'(1) << FL_PLUS;
            CH_MINUS: return 5'(1) << FL_MINUS;
            CH_ZERO:  return 5'(1) << FL_ZERO;
            CH_HASH:  return 5'(1) << FL_HASH;
            CH_SPACE: return 5'(1) << FL_SPACE;
            default:  return '0;
        endcase
    endfunction

    function automatic logic [3:0] mod_of(input logic [7:0] c);
        case (c)
            CH_H:    return MOD_H;
            CH_L:    return MOD_L;
            CH_J:    return MOD_J;
            CH_Z:    return MOD_Z;
            default: return MOD_NONE;
        endcase
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // decimal accumulate, pinned at the largest positive value on overflow
    function automatic logic [31:0] digit_push(input logic [31:0] acc, input logic [31:0] d);
        if (acc > DIGIT_LIMIT || (acc == DIGIT_LIMIT && d > 32'd7))
            return SAT_MAX;
        return acc * 10 + d;
    endfunction

    // Advance the shadow parser by one character. Returns 1 when the character
    // closes a spec; shape then holds the result the block must produce.
    function automatic bit parse_char(input logic [7:0] c, input logic start,
                                      input logic [31:0] arg, output fsp_result_t shape);
        bit         settled;
        bit         emit;
        logic [7:0] conv;
        logic       bad;
        logic [3:0] kind;
        settled = 1'b0;
        emit    = 1'b0;
        conv    = CH_NUL;
        bad     = 1'b0;
        shape   = '0;
        if (start)
        begin
            // a new spec throws away whatever was half parsed
            phase_q = PH_FLAGS;
            flags_q = '0;
            width_q = MINUS_ONE;
            prec_q  = MINUS_ONE;
            mod_q   = MOD_NONE;
            if (c == CH_NUL)
            begin
                emit    = 1'b1;
                settled = 1'b1;
            end
        end
        if (phase_q == PH_IDLE)
            settled = 1'b1;
        // a character that does not belong to a phase falls through to the next
        while (!settled)
        begin
            case (phase_q)
                PH_FLAGS:
                    if (flag_of(c) != '0)
                    begin
                        flags_q |= flag_of(c);
                        settled = 1'b1;
                    end
                    else if (c == CH_STAR)
                    begin
                        // negative star width turns into minus flag plus magnitude
                        if (arg[31])
                        begin
                            flags_q[FL_MINUS] = 1'b1;
                            width_q = (arg == NEG_MIN) ? SAT_MAX : -arg;
                        end
                        else
                            width_q = arg;
                        phase_q = PH_WSKIP;
                        settled = 1'b1;
                    end
                    else if (is_digit(c))
                    begin
                        width_q = 32'(c - CH_ZERO);
                        phase_q = PH_WDIG;
                        settled = 1'b1;
                    end
                    else
                    begin
                        width_q = '0;
                        phase_q = PH_WSKIP;
                    end
                PH_WDIG:
                    if (is_digit(c))
                    begin
                        width_q = digit_push(width_q, 32'(c - CH_ZERO));
                        settled = 1'b1;
                    end
                    else
                        phase_q = PH_WSKIP;
                PH_WSKIP:
                    if (is_digit(c))
                        settled = 1'b1;
                    else if (c == CH_DOT)
                    begin
                        phase_q = PH_PSTART;
                        settled = 1'b1;
                    end
                    else
                        phase_q = PH_MOD;
                PH_PSTART:
                    if (c == CH_STAR)
                    begin
                        prec_q  = arg[31] ? MINUS_ONE : arg;
                        phase_q = PH_PSKIP;
                        settled = 1'b1;
                    end
                    else if (is_digit(c))
                    begin
                        prec_q  = 32'(c - CH_ZERO);
                        phase_q = PH_PDIG;
                        settled = 1'b1;
                    end
                    else
                    begin
                        // bare dot means precision zero
                        prec_q  = '0;
                        phase_q = PH_MOD;
                    end
                PH_PDIG:
                    if (is_digit(c))
                    begin
                        prec_q  = digit_push(prec_q, 32'(c - CH_ZERO));
                        settled = 1'b1;
                    end
                    else
                        phase_q = PH_MOD;
                PH_PSKIP:
                    if (is_digit(c))
                        settled = 1'b1;
                    else
                        phase_q = PH_MOD;
                PH_MOD:
                begin
                    kind    = mod_of(c);
                    settled = 1'b1;
                    if (kind == MOD_NONE)
                    begin
                        emit = 1'b1;
                        conv = c;
                    end
                    else if (mod_q == MOD_NONE)
                        mod_q = kind;
                    else if (mod_q == kind)
                        mod_q = kind + 4'd1;
                    else
                    begin
                        // mixed letters or a third letter
                        emit = 1'b1;
                        bad  = 1'b1;
                    end
                end
                default:
                    settled = 1'b1;
            endcase
        end
        if (emit)
        begin
            shape.flag_plus       = flags_q[FL_PLUS];
            shape.flag_minus      = flags_q[FL_MINUS];
            shape.flag_zero       = flags_q[FL_ZERO];
            shape.flag_hash       = flags_q[FL_HASH];
            shape.flag_space      = flags_q[FL_SPACE];
            shape.field_width     = width_q;
            shape.precision_value = prec_q;
            shape.length_modifier = mod_q;
            shape.conversion_char = conv;
            shape.malformed       = bad;
            phase_q = PH_IDLE;
        end
        return emit;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] c, input bit start, input logic [31:0] arg);
        pend_char_t p;
        p.req.spec_char   = c;
        p.req.starts_spec = start;
        p.req.arg_value   = arg;
        p.drain           = drain_next;
        drain_next        = 1'b0;
        chars_to_send.push_back(p);
    endtask

    // first character of an open spec carries the start mark
    task automatic push_next(input logic [7:0] c, input logic [31:0] arg);
        push_char(c, spec_open, arg);
        spec_open = 1'b0;
    endtask

    task automatic push_spec(input string s, input logic [31:0] arg);
        spec_open = 1'b1;
        for (int i = 0; i < s.len(); i++)
            push_next(s[i], arg);
    endtask

    task automatic push_digits(input int n);
        push_next(CH_ZERO + 8'($urandom_range(1, 9)), $urandom);
        repeat (n - 1)
            push_next(CH_ZERO + 8'($urandom_range(0, 9)), $urandom);
    endtask

    function automatic int digit_count();
        // mostly short numbers, now and then long enough to saturate
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(9, 12);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] star_arg();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return MINUS_ONE;
            2:       return SAT_MAX;
            3:       return NEG_MIN;
            4:       return $urandom_range(0, 99);
            5:       return -$urandom_range(1, 99);
            default: return $urandom;
        endcase
    endfunction

    // one spec: flags, width, precision, modifier, end; some of them broken
    task automatic gen_spec();
        string      flag_chars = "+-0# ";
        string      conv_chars = "diouxXcspfeEgGaAn%";
        string      mod_chars  = "hljz";
        int         pick;
        logic [7:0] m;
        spec_open = 1'b1;
        repeat ($urandom_range(0, 3))
            push_next(flag_chars[$urandom_range(0, 4)], $urandom);
        pick = $urandom_range(0, 5);
        if (pick == 2 || pick == 3)
            push_digits(digit_count());
        else if (pick == 4)
        begin
            push_next(CH_STAR, star_arg());
            if ($urandom_range(0, 3) == 0)
                push_digits(2);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            push_next(CH_DOT, $urandom);
            pick = $urandom_range(0, 2);
            if (pick == 1)
                push_digits(digit_count());
            else if (pick == 2)
            begin
                push_next(CH_STAR, star_arg());
                if ($urandom_range(0, 3) == 0)
                    push_digits(2);
            end
        end
        m    = mod_chars[$urandom_range(0, 3)];
        pick = $urandom_range(0, 9);
        if (pick >= 4 && pick <= 8)
            push_next(m, $urandom);
        if (pick == 7 || pick == 8)
            push_next(m, $urandom);
        if (pick == 9)
        begin
            // three letters: malformed on the second or the third
            push_next(m, $urandom);
            push_next(mod_chars[$urandom_range(0, 3)], $urandom);
            push_next(mod_chars[$urandom_range(0, 3)], $urandom);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
            push_next(CH_NUL, $urandom);
        else if (pick != 1)
            push_next(conv_chars[$urandom_range(0, conv_chars.len() - 1)], $urandom);
        // pick 1 leaves the spec open; the next start abandons it
    endtask

    function automatic int pick_wait(inout int run_left, inout bit no_idle);
        // runs of back-to-back traffic and runs of random idling follow each other at random
        if (run_left == 0)
        begin
            run_left = $urandom_range(10, 60);
            no_idle  = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        if (no_idle)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic check_result(input fsp_result_t got, input logic [6:0] pad);
        fsp_result_t want;
        if (parsed_specs_due.size() == 0)
        begin
            $display("%0t: result with nothing expected, got %h", $time, got);
            fails++;
        end
        else
        begin
            want = parsed_specs_due.pop_front();
            check_field("flag_plus", 32'(want.flag_plus), 32'(got.flag_plus));
            check_field("flag_minus", 32'(want.flag_minus), 32'(got.flag_minus));
            check_field("flag_zero", 32'(want.flag_zero), 32'(got.flag_zero));
            check_field("flag_hash", 32'(want.flag_hash), 32'(got.flag_hash));
            check_field("flag_space", 32'(want.flag_space), 32'(got.flag_space));
            check_field("field_width", want.field_width, got.field_width);
            check_field("precision_value", want.precision_value, got.precision_value);
            check_field("length_modifier", 32'(want.length_modifier),
                        32'(got.length_modifier));
            check_field("conversion_char", 32'(want.conversion_char),
                        32'(got.conversion_char));
            check_field("malformed", 32'(want.malformed), 32'(got.malformed));
            check_field("tdata padding", '0, 32'(pad));
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: presents the next character at the falling edge, after its gap
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || char_taken)
            begin
                if (char_wait > 0)
                begin
                    char_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (chars_to_send.size() != 0 &&
                         (!chars_to_send[0].drain || parsed_specs_due.size() == 0))
                begin
                    char_next = chars_to_send.pop_front();
                    s_tdata  <= {char_next.req.arg_value, char_next.req.spec_char};
                    s_tuser  <= char_next.req.starts_spec;
                    s_tvalid <= 1'b1;
                    char_wait = pick_wait(char_run_left, char_no_idle);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: after each result, hold tready low for a random stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
                res_wait = pick_wait(res_run_left, res_no_idle);
            if (res_wait > 0)
            begin
                res_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Rising edge: record handshakes, predict, check, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            char_taken <= 1'b0;
            res_taken  <= 1'b0;
        end
        else
        begin
            char_taken <= s_tvalid && s_tready;
            res_taken  <= m_tvalid && m_tready;
            if (s_tvalid && s_tready)
            begin
                chars_sent++;
                if (parse_char(s_tdata[7:0], s_tuser[0], s_tdata[39:8], spec_shape))
                    parsed_specs_due.push_back(spec_shape);
            end
            if (m_tvalid && m_tready)
                check_result(fsp_result_t'({m_tuser[0], m_tdata[80:0]}), m_tdata[87:81]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= IDLE_LIMIT)
                begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Build the whole stimulus, run reset, wait for the traffic to drain
    // ------------------------------------------------------------------
    initial
    begin
        // directed: empty spec, every flag, star extremes, overflow, bad modifiers
        push_char(CH_NUL, 1'b1, '0);
        push_spec("+-0# *.*12hhd", NEG_MIN);
        push_spec("9999999999.zx", $urandom);
        push_spec("*.lli", SAT_MAX);
        push_spec("-*hl", -32'sd5);
        push_char("x", 1'b0, $urandom);           // idle, dropped
        push_spec("7.", '0);
        push_spec("jjzu", '0);                    // restart mid-spec, then third letter
        push_spec("12.99999999999", '0);
        push_char(CH_NUL, 1'b0, '0);              // terminator closes the spec
        drain_next = 1'b1;
        next_drain = chars_to_send.size() + DRAIN_EVERY;
        char_total = chars_to_send.size() + RANDOM_CHARS;
        while (chars_to_send.size() < char_total)
        begin
            if (chars_to_send.size() >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain += DRAIN_EVERY;
            end
            if ($urandom_range(0, 9) == 0)
                push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, $urandom);
            else
                gen_spec();
        end
        char_total = chars_to_send.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (chars_sent != char_total || parsed_specs_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
